/* design/rtks_pkg.sv */
// ----------------------------------------------------------------------------
// rtks_pkg: shared types for the row top-k selector
// Field widths and the control group that the top level sends to each cell.
// ----------------------------------------------------------------------------
package rtks_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 16;
  localparam int KCFG_W  = 5;
  localparam logic [KCFG_W-1:0] K_RESET = KCFG_W'(16);

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [POS_W-1:0]          pos_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic insert;  // an element transfer is being inserted
    logic accept;  // the element lands inside the first k entries
    logic last;    // that element closes the row
    logic shift;   // result transfer: move the chain one cell toward the head
  } cell_ctrl_t;

endpackage

/* design/row_top_k_select_top.sv */
// ----------------------------------------------------------------------------
// row_top_k_select_top: streaming top-k selector over rows
// Keeps the k largest signed values of each row in a sorted chain of cells
// and reports them, largest first, when the row ends.
// ----------------------------------------------------------------------------
// Elements of a row are taken one per cycle: each transfer is compared
// against all K_MAX cells of the insertion chain at once and lands in its
// sorted place in the same cycle. On the element that carries tlast the
// block stops taking input and drains min(k, N) results, N being the
// row's element count, from the head cell of the chain, one per output
// transfer, largest value first, equal values in row order; the final one
// carries tlast. The chain shifts one cell per output transfer, and the
// next row's first element is taken in the cycle after the last result
// leaves. k is the configured count, with 0 read as 1 and counts above
// K_MAX read as K_MAX; write it only between rows. Positions count from
// zero and stick at min(ROW_MAX, 65536) - 1 in an overlong row.
// ----------------------------------------------------------------------------
module row_top_k_select_top #(
  parameter int K_MAX   = 16,
  parameter int ROW_MAX = 65536
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: k_count
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  // element stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tlast,   // row_end
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [31:0] top_value, [47:32] position
  output logic        m_tlast    // burst_end
);
  import rtks_pkg::*;

  localparam int KW = $clog2(K_MAX + 1);
  localparam pos_t POS_LIMIT = (ROW_MAX > 65536) ? pos_t'(65535) : pos_t'(ROW_MAX - 1);

  logic [KCFG_W-1:0] k_count;
  logic [KW-1:0]     k_eff;
  pos_t              row_position;
  logic              draining;   // result burst in progress, input held off

  cell_ctrl_t        ctrl;
  logic              in_xfer;
  logic              out_xfer;
  value_t            new_value;

  value_t            cv     [K_MAX];
  pos_t              cp     [K_MAX];
  logic [K_MAX-1:0]  cvalid;
  logic [K_MAX-1:0]  cge;
  logic [K_MAX-1:0]  in_k;

  assign new_value = value_t'(s_tdata);
  assign s_tready  = !draining;
  assign in_xfer   = s_tvalid && s_tready;
  assign out_xfer  = m_tvalid && m_tready;

  // Effective k: zero reads as one, large counts clamp to the chain length
  always_comb begin
    if (k_count == '0) begin
      k_eff = KW'(1);
    end else if (32'(k_count) > K_MAX) begin
      k_eff = KW'(K_MAX);
    end else begin
      k_eff = KW'(k_count);
    end
  end

  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      in_k[i] = (i < 32'(k_eff));
    end
  end

  // The greater-or-equal flags form a prefix, so the element fits within
  // the first k slots when any of those slots is not greater or equal.
  always_comb begin
    ctrl.insert = in_xfer;
    ctrl.accept = |(~cge & in_k);
    ctrl.last   = s_tlast;
    ctrl.shift  = out_xfer;
  end

  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    value_t lv;
    pos_t   lp;
    logic   lval;
    logic   lge;
    value_t rv;
    pos_t   rp;
    logic   rval;

    if (i == 0) begin : g_head
      // head slot sees an "always ahead" left neighbor
      assign lv   = new_value;
      assign lp   = row_position;
      assign lval = 1'b1;
      assign lge  = 1'b1;
    end else begin : g_body
      assign lv   = cv[i-1];
      assign lp   = cp[i-1];
      assign lval = cvalid[i-1];
      assign lge  = cge[i-1];
    end

    if (i == K_MAX - 1) begin : g_tail
      assign rv   = new_value;
      assign rp   = row_position;
      assign rval = 1'b0;
    end else begin : g_inner
      assign rv   = cv[i+1];
      assign rp   = cp[i+1];
      assign rval = cvalid[i+1];
    end

    rtks_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .in_k        (in_k[i]),
      .new_value   (new_value),
      .new_pos     (row_position),
      .left_value  (lv),
      .left_pos    (lp),
      .left_valid  (lval),
      .left_ge     (lge),
      .right_value (rv),
      .right_pos   (rp),
      .right_valid (rval),
      .value       (cv[i]),
      .pos         (cp[i]),
      .valid       (cvalid[i]),
      .ge          (cge[i])
    );
  end

  // Results come straight from the head cell
  assign m_tvalid = draining && cvalid[0];
  assign m_tdata  = {cp[0], cv[0]};
  generate
    if (K_MAX > 1) begin : g_last_multi
      assign m_tlast = !cvalid[1];
    end else begin : g_last_single
      assign m_tlast = 1'b1;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      k_count      <= K_RESET;
      row_position <= '0;
      draining     <= 1'b0;
    end else begin
      if (cfg_we) begin
        k_count <= cfg_wdata;
      end
      if (in_xfer) begin
        if (s_tlast) begin
          row_position <= '0;
          draining     <= 1'b1;
        end else if (row_position < POS_LIMIT) begin
          row_position <= row_position + pos_t'(1);
        end
      end
      if (out_xfer && m_tlast) begin
        draining <= 1'b0;
      end
    end
  end

endmodule

/* design/rtks_cell.sv */
// ----------------------------------------------------------------------------
// rtks_cell: one slot of the sorted insertion chain
// Holds one kept value and its position; takes the new element, its left
// neighbor's entry, or keeps its own, and shifts toward the head on readout.
// ----------------------------------------------------------------------------
module rtks_cell (
  input  logic                clk,
  input  logic                rst,
  input  rtks_pkg::cell_ctrl_t ctrl,
  input  logic                in_k,       // this slot lies below the active k
  input  rtks_pkg::value_t    new_value,
  input  rtks_pkg::pos_t      new_pos,
  input  rtks_pkg::value_t    left_value,
  input  rtks_pkg::pos_t      left_pos,
  input  logic                left_valid,
  input  logic                left_ge,
  input  rtks_pkg::value_t    right_value,
  input  rtks_pkg::pos_t      right_pos,
  input  logic                right_valid,
  output rtks_pkg::value_t    value,
  output rtks_pkg::pos_t      pos,
  output logic                valid,
  output logic                ge
);
  import rtks_pkg::*;

  logic valid_next;

  // Kept entry is greater or equal: new element goes somewhere after it
  assign ge = valid && (value >= new_value);

  always_comb begin
    valid_next = valid;
    if (ctrl.shift) begin
      valid_next = right_valid;
    end else if (ctrl.insert) begin
      if (ctrl.accept) begin
        valid_next = (valid | left_valid) & in_k;
      end
      if (ctrl.last) begin
        valid_next = valid_next & in_k;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= right_value;
      pos   <= right_pos;
    end else if (ctrl.insert && ctrl.accept && !ge) begin
      if (left_ge) begin
        value <= new_value;
        pos   <= new_pos;
      end else begin
        value <= left_value;
        pos   <= left_pos;
      end
    end
  end

endmodule
